// ----- rtl/rmc_pkg.sv -----
`default_nettype none

package rmc_pkg;

    // Default values for the top-level parameters.
    localparam int MAP_SIDE_DEF       = 64;
    localparam int MAX_COLUMNS_DEF    = 1024;
    localparam int CEILING_OFFSET_DEF = 25;
    localparam int FLOOR_OFFSET_DEF   = 25;
    localparam int TRIG_ENTRIES_DEF   = 1024;

    // Fixed-point formats settled by the field widths.
    localparam int FRAC_BITS = 8;
    localparam int TRIG_BITS = 14;
    localparam int CFG_W     = 14;
    localparam int NUM_W     = 22;
    localparam int DVS_W     = 20;

    // Configuration register indexes.
    localparam logic [2:0] REG_PLAYER_X     = 3'd0;
    localparam logic [2:0] REG_PLAYER_Y     = 3'd1;
    localparam logic [2:0] REG_VIEW_ANGLE   = 3'd2;
    localparam logic [2:0] REG_FOV_DEG      = 3'd3;
    localparam logic [2:0] REG_COLUMN_COUNT = 3'd4;
    localparam logic [2:0] REG_MARCH_STEP   = 3'd5;
    localparam logic [2:0] REG_VIEW_RANGE   = 3'd6;
    localparam logic [2:0] REG_HEIGHT_SCALE = 3'd7;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] column;
    } cmd_word_t;

    typedef struct packed {
        logic        hit;
        logic [14:0] distance;
        logic [10:0] wall_top;
        logic [10:0] wall_bottom;
        logic [7:0]  shade;
    } result_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROD,
        ST_SUM,
        ST_DIV,
        ST_ROM,
        ST_TRIG,
        ST_STEPMUL,
        ST_MARCH,
        ST_POST,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/rmc_map_mem.sv -----
`default_nettype none

// Wall map: one bit per cell, cleared by a sweep after reset.
module rmc_map_mem
    import rmc_pkg::*;
#(
    parameter int MAP_SIDE = MAP_SIDE_DEF,
    localparam int DEPTH = MAP_SIDE * MAP_SIDE,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_data,
    output logic               clearing
);

    logic          mem [0:DEPTH-1];
    logic [AW-1:0] clr_cnt_reg;
    logic          clearing_reg;
    logic          rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

// ----- rtl/rmc_trig_rom.sv -----
`default_nettype none

// Quarter-wave sine table in Q1.14, two registered read ports.
module rmc_trig_rom
    import rmc_pkg::*;
#(
    parameter int TRIG_ENTRIES = TRIG_ENTRIES_DEF,
    localparam int QN = TRIG_ENTRIES / 4,
    localparam int AW = $clog2(QN + 1)
)
(
    input  wire logic          clk,
    input  wire logic [AW-1:0] addr_a,
    input  wire logic [AW-1:0] addr_b,
    output logic [14:0]        data_a,
    output logic [14:0]        data_b
);

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;

    typedef logic [14:0] qtab_t [0:QN];

    // Multiplies a series term by x squared, both in Q2.30.
    function automatic longint sq_term(input longint term, input longint x);
        longint v;
        v = term * x / Q30_ONE;
        return v * x / Q30_ONE;
    endfunction

    // sin(t/TRIG_ENTRIES * pi/2) by a Taylor series, evaluated at elaboration.
    // Each term is the previous one times -x*x/((2n)(2n+1)).
    function automatic logic [14:0] quarter_sine(input longint t);
        longint x;
        longint sum;
        longint term;
        longint r;
        x = (t * HALF_PI_Q30) / TRIG_ENTRIES;
        sum = x;
        term = x;
        term = -sq_term(term, x) / 64'sd6;
        sum = sum + term;
        term = -sq_term(term, x) / 64'sd20;
        sum = sum + term;
        term = -sq_term(term, x) / 64'sd42;
        sum = sum + term;
        term = -sq_term(term, x) / 64'sd72;
        sum = sum + term;
        term = -sq_term(term, x) / 64'sd110;
        sum = sum + term;
        term = -sq_term(term, x) / 64'sd156;
        sum = sum + term;
        term = -sq_term(term, x) / 64'sd210;
        sum = sum + term;
        term = -sq_term(term, x) / 64'sd272;
        sum = sum + term;
        r = sum + 32768;
        if (r < 0)
        begin
            r = 0;
        end
        r = r / 65536;
        if (r > 16384)
        begin
            r = 16384;
        end
        return 15'(r);
    endfunction

    function automatic qtab_t build_tab();
        qtab_t tab;
        for (int m = 0; m <= QN; m++)
        begin
            tab[m] = quarter_sine(longint'(4 * m));
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_tab();

    logic [14:0] data_a_reg;
    logic [14:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        data_a_reg <= QTAB[addr_a];
        data_b_reg <= QTAB[addr_b];
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

`default_nettype wire

// ----- rtl/rmc_angle_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle; keeps the low quotient bits.
module rmc_angle_div
    import rmc_pkg::*;
#(
    parameter int TB = 10,
    localparam int DVD_W = NUM_W + TB,
    localparam int CW = $clog2(DVD_W + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [TB-1:0]         quot
);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_reg;
    logic [TB-1:0]    quot_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DVD_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg  <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            quot_reg <= {quot_reg[TB-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/grid_ray_march_column_caster.sv -----
`default_nettype none

// Column ray caster over a square grid wall map.
// Commands arrive on cmd and are taken at a rising edge where start is high
// and busy is low. A word with mode 0 writes one map cell (a wall when its
// colour sums to zero) and finishes in that cycle with no result, so the next
// word can be taken at the following edge. A word with mode 1 casts the ray
// for one screen column and later yields one result word on result, valid for
// exactly one cycle while done is high; the receiver cannot hold it off.
// A cast spends its setup on three multiplies, the restoring angle division
// of 22 plus log2(TRIG_ENTRIES) steps, the sine table read and the step
// products, then marches one sample a cycle, since the single read port
// gives one sample a cycle, with a last march step that checks the final map
// read; the result is then formed in ST_POST and ST_EMIT, and done is high in
// the cycle after ST_EMIT, when busy is already low again. A ray that runs to
// full range at the reset settings takes 493 samples.
// Configuration registers are written through cfg_we, cfg_index and cfg_data,
// one register per cycle, and should only change while busy is low.
// After reset the map is swept clear, one cell per cycle over all MAP_SIDE
// squared cells (4096 at the default size); busy stays high during the sweep.
module grid_ray_march_column_caster
    import rmc_pkg::*;
#(
    parameter int MAP_SIDE       = MAP_SIDE_DEF,
    parameter int MAX_COLUMNS    = MAX_COLUMNS_DEF,
    parameter int CEILING_OFFSET = CEILING_OFFSET_DEF,
    parameter int FLOOR_OFFSET   = FLOOR_OFFSET_DEF,
    parameter int TRIG_ENTRIES   = TRIG_ENTRIES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cmd_word_t        cmd,
    output logic                  done,
    output result_word_t          result,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int TB     = $clog2(TRIG_ENTRIES);
    localparam int QN     = TRIG_ENTRIES / 4;
    localparam int RAW    = $clog2(QN + 1);
    localparam int MAP_AW = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int DVD_W  = NUM_W + TB;
    localparam int PH_W   = 27;

    // Configuration registers.
    logic [13:0] player_x_reg;
    logic [13:0] player_y_reg;
    logic [8:0]  view_angle_reg;
    logic [8:0]  fov_deg_reg;
    logic [10:0] column_count_reg;
    logic [7:0]  march_step_reg;
    logic [6:0]  view_range_reg;
    logic [10:0] height_scale_reg;

    state_t state_reg;
    state_t state_next;

    // Per-cast working registers.
    logic [10:0]        cc_reg;
    logic [9:0]         column_reg;
    logic [19:0]        p_va_reg;
    logic [18:0]        p_col_reg;
    logic [19:0]        p_fov_reg;
    logic [TB-1:0]      idx_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic signed [24:0] dx_reg;
    logic signed [24:0] dy_reg;
    logic signed [31:0] fx_reg;
    logic signed [31:0] fy_reg;
    logic [14:0]        j_reg;
    logic [14:0]        pend_j_reg;
    logic               pend_valid_reg;
    logic [14:0]        dist_reg;
    logic               hit_reg;
    logic [PH_W-1:0]    ph_reg;
    logic [19:0]        dim_reg;
    result_word_t       result_reg;
    logic               done_reg;

    // Combinational helpers.
    logic               accept;
    logic [10:0]        cc_eff;
    logic [7:0]         step_eff;
    logic [14:0]        limit;
    logic [NUM_W-1:0]   num;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
    logic               div_go;
    logic               div_done;
    logic [TB-1:0]      div_quot;
    logic [RAW-1:0]     rom_addr_a;
    logic [RAW-1:0]     rom_addr_b;
    logic [14:0]        rom_a;
    logic [14:0]        rom_b;
    logic [1:0]         quad;
    logic [8:0]         cx;
    logic [8:0]         cy;
    logic               out_of_map;
    logic               range_end;
    logic               terminal;
    logic               wall;
    logic               map_wr_en;
    logic [MAP_AW-1:0]  map_wr_addr;
    logic               map_wr_data;
    logic [MAP_AW-1:0]  map_rd_addr;
    logic               map_rd_data;
    logic               map_clearing;
    logic [PH_W-1:0]    top_full;
    logic [PH_W-1:0]    low_full;
    result_word_t       result_next;

    rmc_map_mem #(.MAP_SIDE(MAP_SIDE)) u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (map_wr_en),
        .wr_addr  (map_wr_addr),
        .wr_data  (map_wr_data),
        .rd_addr  (map_rd_addr),
        .rd_data  (map_rd_data),
        .clearing (map_clearing)
    );

    rmc_trig_rom #(.TRIG_ENTRIES(TRIG_ENTRIES)) u_rom (
        .clk    (clk),
        .addr_a (rom_addr_a),
        .addr_b (rom_addr_b),
        .data_a (rom_a),
        .data_b (rom_b)
    );

    rmc_angle_div #(.TB(TB)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign accept = start && (state_reg == ST_IDLE);

    // Effective column count: zero acts as one, large values clamp.
    always_comb
    begin
        if (column_count_reg == 11'd0)
        begin
            cc_eff = 11'd1;
        end
        else if (32'(column_count_reg) > MAX_COLUMNS)
        begin
            cc_eff = 11'(MAX_COLUMNS);
        end
        else
        begin
            cc_eff = column_count_reg;
        end
        step_eff = (march_step_reg == 8'd0) ? 8'd1 : march_step_reg;
        limit    = {view_range_reg, 8'd0};
    end

    // Angle scaled by twice the column count, one turn added to stay positive.
    always_comb
    begin
        num = NUM_W'({p_va_reg, 1'b0}) + NUM_W'({p_col_reg, 1'b0})
            + NUM_W'(cc_reg) * NUM_W'(720) - NUM_W'(p_fov_reg);
        dividend = (DVD_W'(num) << TB) + DVD_W'(cc_reg) * DVD_W'(360);
        divisor  = DVS_W'(cc_reg) * DVS_W'(720);
    end

    // Quarter-wave table addressing.
    always_comb
    begin
        quad       = idx_reg[TB-1 -: 2];
        rom_addr_a = RAW'(idx_reg[TB-3:0]);
        rom_addr_b = RAW'(QN) - RAW'(idx_reg[TB-3:0]);
    end

    // March sample decode.
    always_comb
    begin
        cx          = fx_reg[30:22];
        cy          = fy_reg[30:22];
        out_of_map  = fx_reg[31] || fy_reg[31]
                   || (32'(cx) >= MAP_SIDE) || (32'(cy) >= MAP_SIDE);
        range_end   = (j_reg >= limit);
        terminal    = out_of_map || range_end;
        wall        = pend_valid_reg && map_rd_data;
        map_rd_addr = MAP_AW'(32'(cx) * MAP_SIDE + 32'(cy));
        map_wr_en   = accept && (cmd.mode == MODE_WRITE)
                   && (32'(cmd.cell_x) < MAP_SIDE) && (32'(cmd.cell_y) < MAP_SIDE);
        map_wr_addr = MAP_AW'(32'(cmd.cell_x) * MAP_SIDE + 32'(cmd.cell_y));
        map_wr_data = ({2'b00, cmd.red} + {2'b00, cmd.green} + {2'b00, cmd.blue})
                   == 10'd0;
    end

    // Result formation.
    always_comb
    begin
        top_full = (ph_reg + PH_W'(CEILING_OFFSET * (1 << FRAC_BITS))) >> (FRAC_BITS + 1);
        low_full = (ph_reg + PH_W'(FLOOR_OFFSET * (1 << FRAC_BITS))) >> (FRAC_BITS + 1);
        result_next          = '0;
        result_next.hit      = hit_reg;
        result_next.distance = dist_reg;
        if (hit_reg)
        begin
            result_next.wall_top = (top_full > PH_W'(cc_reg)) ? cc_reg : 11'(top_full);
            result_next.wall_bottom = (low_full >= PH_W'(cc_reg)) ? 11'd0
                                    : cc_reg - 11'(low_full);
            result_next.shade = (dim_reg[19:8] >= 12'd255) ? 8'd0
                              : 8'd255 - 8'(dim_reg[19:8]);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!map_clearing)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (cmd.mode == MODE_CAST))
                begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ROM;
                end
            end
            ST_ROM:     state_next = ST_TRIG;
            ST_TRIG:    state_next = ST_STEPMUL;
            ST_STEPMUL: state_next = ST_MARCH;
            ST_MARCH:
            begin
                if (wall || terminal)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:    state_next = ST_EMIT;
            ST_EMIT:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        busy   = 1'b1;
        div_go = 1'b0;
        unique case (state_reg)
            ST_IDLE: busy   = 1'b0;
            ST_SUM:  div_go = 1'b1;
            default: busy   = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            player_x_reg     <= 14'd768;
            player_y_reg     <= 14'd768;
            view_angle_reg   <= 9'd0;
            fov_deg_reg      <= 9'd90;
            column_count_reg <= 11'd256;
            march_step_reg   <= 8'd26;
            view_range_reg   <= 7'd50;
            height_scale_reg <= 11'd17;
            pend_valid_reg   <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EMIT);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PLAYER_X:     player_x_reg     <= cfg_data[13:0];
                    REG_PLAYER_Y:     player_y_reg     <= cfg_data[13:0];
                    REG_VIEW_ANGLE:   view_angle_reg   <= cfg_data[8:0];
                    REG_FOV_DEG:      fov_deg_reg      <= cfg_data[8:0];
                    REG_COLUMN_COUNT: column_count_reg <= cfg_data[10:0];
                    REG_MARCH_STEP:   march_step_reg   <= cfg_data[7:0];
                    REG_VIEW_RANGE:   view_range_reg   <= cfg_data[6:0];
                    REG_HEIGHT_SCALE: height_scale_reg <= cfg_data[10:0];
                    default:          player_x_reg     <= player_x_reg;
                endcase
            end
            if (state_reg == ST_STEPMUL)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if ((state_reg == ST_MARCH) && !wall && !terminal)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cc_reg     <= cc_eff;
            column_reg <= cmd.column;
        end
        if (state_reg == ST_PROD)
        begin
            p_va_reg  <= 20'(cc_reg) * 20'(view_angle_reg);
            p_col_reg <= 19'(column_reg) * 19'(fov_deg_reg);
            p_fov_reg <= 20'(fov_deg_reg) * 20'(cc_reg);
        end
        if (div_done)
        begin
            idx_reg <= div_quot;
        end
        if (state_reg == ST_TRIG)
        begin
            case (quad)
                2'd0:
                begin
                    sin_reg <= $signed({1'b0, rom_a});
                    cos_reg <= $signed({1'b0, rom_b});
                end
                2'd1:
                begin
                    sin_reg <= $signed({1'b0, rom_b});
                    cos_reg <= -$signed({1'b0, rom_a});
                end
                2'd2:
                begin
                    sin_reg <= -$signed({1'b0, rom_a});
                    cos_reg <= -$signed({1'b0, rom_b});
                end
                default:
                begin
                    sin_reg <= -$signed({1'b0, rom_b});
                    cos_reg <= $signed({1'b0, rom_a});
                end
            endcase
        end
        if (state_reg == ST_STEPMUL)
        begin
            dx_reg <= $signed({1'b0, step_eff}) * cos_reg;
            dy_reg <= $signed({1'b0, step_eff}) * sin_reg;
            fx_reg <= $signed({4'd0, player_x_reg, 14'd0});
            fy_reg <= $signed({4'd0, player_y_reg, 14'd0});
            j_reg  <= 15'd0;
        end
        if (state_reg == ST_MARCH)
        begin
            if (wall)
            begin
                hit_reg  <= 1'b1;
                dist_reg <= pend_j_reg;
            end
            else if (terminal)
            begin
                hit_reg  <= 1'b0;
                dist_reg <= limit;
            end
            else
            begin
                pend_j_reg <= j_reg;
                j_reg      <= j_reg + 15'(step_eff);
                fx_reg     <= fx_reg + 32'(dx_reg);
                fy_reg     <= fy_reg + 32'(dy_reg);
            end
        end
        if (state_reg == ST_POST)
        begin
            ph_reg  <= PH_W'(dist_reg) * PH_W'(height_scale_reg);
            dim_reg <= 20'(dist_reg) * 20'd30;
        end
        if (state_reg == ST_EMIT)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
